@@ sv/acr_pkg.sv @@
// Shared types, codes and constants for the ARP cache responder.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package acr_pkg;

   localparam int MAC_BYTES = 6;
   localparam int MAC_W = 8 * MAC_BYTES;
   localparam int IP_W = 32;
   localparam int IFACE_W = 2;

   localparam int DEFAULT_CACHE_ENTRIES = 16;
   localparam int DEFAULT_PORT_COUNT = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY = 16'd2;
   localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_BYTES{8'hFF}};

   localparam logic [2:0] OP_RECEIVE = 3'd0;
   localparam logic [2:0] OP_LOOKUP = 3'd1;
   localparam logic [2:0] OP_ADD = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_SEND_REQUEST = 3'd4;

   localparam logic [2:0] CMD_NONE = 3'd0;
   localparam logic [2:0] CMD_STORE = 3'd1;
   localparam logic [2:0] CMD_LOOKUP = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_SEND_REQ = 3'd4;
   localparam logic [2:0] CMD_NOT_FOUND = 3'd5;
   localparam logic [2:0] CMD_BAD_PROTO = 3'd6;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_BAD_PROTOCOL = 2'd2;

   localparam logic [1:0] CSR_OWN_IP = 2'd1;

   typedef struct packed {
      logic [2:0]         code;
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      logic [IFACE_W-1:0] port;
      logic               reply;
   } cmd_type;

   // Declared from the top bit down so that hit lands in bit 0.
   typedef struct packed {
      logic [IFACE_W-1:0] send_interface;
      logic [IP_W-1:0]    send_sender_ip;
      logic [IP_W-1:0]    send_target_ip;
      logic [MAC_W-1:0]   send_target_mac;
      logic [MAC_W-1:0]   send_dest_mac;
      logic [1:0]         send_opcode;
      logic               send_valid;
      logic [IFACE_W-1:0] found_interface;
      logic [MAC_W-1:0]   found_mac;
      logic               hit;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/acr_front.sv @@
// Front end: accepts request transfers, decodes the operation into a cache command
// and holds it in one stage until the command queue takes it. Uses acr_pkg.
`default_nettype none
module acr_front #(
   parameter int PORT_COUNT = acr_pkg::DEFAULT_PORT_COUNT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [acr_pkg::IP_W-1:0] own_ip,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [183:0]             req_tdata,
   input  wire logic [2:0]               req_tuser,
   output logic                          push_valid,
   input  wire logic                     push_ready,
   output acr_pkg::cmd_type              push_cmd
);
   import acr_pkg::*;

   localparam logic [4:0] PORT_LIMIT = 5'(PORT_COUNT);

   logic [15:0]        protocol_type;
   logic [15:0]        arp_opcode;
   logic [MAC_W-1:0]   sender_mac;
   logic [IP_W-1:0]    sender_ip;
   logic [IP_W-1:0]    target_ip;
   logic [IP_W-1:0]    key_ip;
   logic [IFACE_W-1:0] interface_req;
   logic               port_ok;
   logic               reply;
   cmd_type            cmd;
   logic               valid_ff, valid_in;
   cmd_type            cmd_ff, cmd_in;
   logic               accept;

   assign protocol_type = req_tdata[15:0];
   assign arp_opcode    = req_tdata[31:16];
   assign sender_mac    = req_tdata[79:32];
   assign sender_ip     = req_tdata[111:80];
   assign target_ip     = req_tdata[143:112];
   assign key_ip        = req_tdata[175:144];
   assign interface_req = req_tdata[177:176];

   assign port_ok = {3'b000, interface_req} < PORT_LIMIT;
   assign reply = (arp_opcode == ARP_OP_REQUEST) && (own_ip != '0)
                  && (target_ip == own_ip);

   always_comb begin
      cmd.code  = CMD_NONE;
      cmd.ip    = key_ip;
      cmd.mac   = sender_mac;
      cmd.port  = interface_req;
      cmd.reply = 1'b0;
      case (req_tuser)
         OP_RECEIVE: begin
            cmd.ip = sender_ip;
            if (!port_ok) begin
               cmd.code = CMD_NOT_FOUND;
            end else if (protocol_type != ETH_TYPE_IPV4) begin
               cmd.code = CMD_BAD_PROTO;
            end else begin
               cmd.code  = CMD_STORE;
               cmd.reply = reply;
            end
         end
         OP_LOOKUP: begin
            cmd.code = CMD_LOOKUP;
         end
         OP_ADD: begin
            cmd.code = port_ok ? CMD_STORE : CMD_NOT_FOUND;
         end
         OP_REMOVE: begin
            cmd.code = CMD_REMOVE;
         end
         OP_SEND_REQUEST: begin
            cmd.code = port_ok ? CMD_SEND_REQ : CMD_NOT_FOUND;
         end
         default: begin
            cmd.code = CMD_NONE;
         end
      endcase
   end

   assign req_tready = !valid_ff || push_ready;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (accept) begin
         valid_in = 1'b1;
         cmd_in   = cmd;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

endmodule
`default_nettype wire

@@ sv/acr_queue.sv @@
// Short command queue between the decoder and the cache engine.
// Uses acr_pkg for the command type and the queue depth.
`default_nettype none
module acr_queue (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   output logic            push_ready,
   input  wire acr_pkg::cmd_type push_cmd,
   output logic            pop_valid,
   input  wire logic       pop_ready,
   output acr_pkg::cmd_type pop_cmd
);
   import acr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ sv/acr_back.sv @@
// Cache engine: holds the ARP table, executes queued commands and drives the
// registered response stream. Uses acr_pkg for commands, codes and the result type.
`default_nettype none
module acr_back #(
   parameter int CACHE_ENTRIES = acr_pkg::DEFAULT_CACHE_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [acr_pkg::IP_W-1:0] own_ip,
   input  wire logic                     pop_valid,
   output logic                          pop_ready,
   input  wire acr_pkg::cmd_type         pop_cmd,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_status,
   output acr_pkg::rsp_type              rsp_data
);
   import acr_pkg::*;

   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam int ENTRY_W = MAC_W + IFACE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   function automatic logic [IDX_W-1:0] lowest_set(input logic [CACHE_ENTRIES-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   logic [1:0]               state_ff, state_in;
   cmd_type                  cmd_ff;
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic [IP_W-1:0]          ip_ff [CACHE_ENTRIES];
   logic [ENTRY_W-1:0]       entry_mem [CACHE_ENTRIES];
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic [CACHE_ENTRIES-1:0] match_ff, match_in;
   logic [CACHE_ENTRIES-1:0] free_ff;
   logic [IDX_W-1:0]         rp_ff, rp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     take;
   logic                     hit_any;
   logic                     free_any;
   logic [IDX_W-1:0]         hit_slot;
   logic [IDX_W-1:0]         store_slot;
   logic                     out_free;
   logic                     wr_en;
   logic                     rd_en;
   logic                     load;

   assign pop_ready = (state_ff == ST_IDLE);
   assign take      = pop_valid && pop_ready;
   assign hit_any   = |match_ff;
   assign free_any  = |free_ff;
   assign hit_slot  = lowest_set(match_ff);
   assign store_slot = hit_any ? hit_slot : (free_any ? lowest_set(free_ff) : rp_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (ip_ff[i] == pop_cmd.ip);
      end
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      rp_in         = rp_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      load          = 1'b0;
      rsp_status_in = STATUS_DONE;
      rsp_data_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd_ff.code == CMD_LOOKUP && hit_any) begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end else if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               case (cmd_ff.code)
                  CMD_STORE: begin
                     wr_en                = 1'b1;
                     valid_in[store_slot] = 1'b1;
                     if (!hit_any && !free_any) begin
                        rp_in = (rp_ff == LAST_IDX) ? '0 : rp_ff + 1'b1;
                     end
                     if (cmd_ff.reply) begin
                        rsp_data_in.send_valid      = 1'b1;
                        rsp_data_in.send_opcode     = ARP_OP_REPLY[1:0];
                        rsp_data_in.send_dest_mac   = cmd_ff.mac;
                        rsp_data_in.send_target_mac = cmd_ff.mac;
                        rsp_data_in.send_target_ip  = cmd_ff.ip;
                        rsp_data_in.send_sender_ip  = own_ip;
                        rsp_data_in.send_interface  = cmd_ff.port;
                     end
                  end
                  CMD_LOOKUP: begin
                     rsp_status_in = STATUS_NOT_FOUND;
                  end
                  CMD_REMOVE: begin
                     if (hit_any) begin
                        valid_in[hit_slot] = 1'b0;
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  CMD_SEND_REQ: begin
                     rsp_data_in.send_valid      = 1'b1;
                     rsp_data_in.send_opcode     = ARP_OP_REQUEST[1:0];
                     rsp_data_in.send_dest_mac   = BCAST_MAC;
                     rsp_data_in.send_target_ip  = cmd_ff.ip;
                     rsp_data_in.send_sender_ip  = own_ip;
                     rsp_data_in.send_interface  = cmd_ff.port;
                  end
                  CMD_NOT_FOUND: begin
                     rsp_status_in = STATUS_NOT_FOUND;
                  end
                  CMD_BAD_PROTO: begin
                     rsp_status_in = STATUS_BAD_PROTOCOL;
                  end
                  default: begin
                     rsp_status_in = STATUS_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               load                        = 1'b1;
               state_in                    = ST_IDLE;
               rsp_data_in.hit             = 1'b1;
               rsp_data_in.found_mac       = rd_data_ff[ENTRY_W-1:IFACE_W];
               rsp_data_in.found_interface = rd_data_ff[IFACE_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         cmd_ff   <= pop_cmd;
         match_ff <= match_in;
         free_ff  <= ~valid_ff;
      end
      if (wr_en) begin
         ip_ff[store_slot] <= cmd_ff.ip;
      end
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[store_slot] <= {cmd_ff.mac, cmd_ff.port};
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[hit_slot];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

@@ sv/arp_cache_responder.sv @@
// ARP cache and responder: top level with the register port, decoder, queue and cache engine.
// A request passes the decoder register and the queue; the cache engine then matches it,
// executes it (a lookup that hits also reads the entry memory) and registers the response.
// Commands queued ahead and response stalls delay it. The cache engine takes no new command
// until it has loaded the response for the current one.
// Reset is synchronous: the table reads empty, the replacement pointer and own IP go to zero.
`default_nettype none
module arp_cache_responder #(
   parameter int CACHE_ENTRIES = acr_pkg::DEFAULT_CACHE_ENTRIES,
   parameter int PORT_COUNT    = acr_pkg::DEFAULT_PORT_COUNT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [acr_pkg::MAC_W-1:0] csr_data,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // protocol_type, arp_opcode, sender_mac, sender_ip, target_ip, key_ip, interface_req
   input  wire logic [183:0]              req_tdata,
   // operation
   input  wire logic [2:0]                req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // hit, found_mac, found_interface, send_valid, send_opcode, send_dest_mac,
   // send_target_mac, send_target_ip, send_sender_ip, send_interface
   output logic [215:0]                   rsp_tdata,
   // status
   output logic [1:0]                     rsp_tuser
);
   import acr_pkg::*;

   logic [IP_W-1:0] own_ip_ff, own_ip_in;
   logic            push_valid;
   logic            push_ready;
   cmd_type         push_cmd;
   logic            pop_valid;
   logic            pop_ready;
   cmd_type         pop_cmd;
   rsp_type         rsp_data;

   // Writes to the interface MAC have no effect here.
   assign csr_ready = 1'b1;

   always_comb begin
      own_ip_in = own_ip_ff;
      if (csr_valid && csr_index == CSR_OWN_IP) begin
         own_ip_in = csr_data[IP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
      end else begin
         own_ip_ff <= own_ip_in;
      end
   end

   acr_front #(
      .PORT_COUNT(PORT_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .own_ip     (own_ip_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   acr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   acr_back #(
      .CACHE_ENTRIES(CACHE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .own_ip     (own_ip_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule
`default_nettype wire

@@ sv/acr_checker.sv @@
// Port-level checks on the response stream of the ARP cache responder,
// bound to the top level. Uses acr_pkg for the status and opcode codes.
`default_nettype none
module acr_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [215:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);
   import acr_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response transfer changed");

   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tuser == STATUS_DONE && !rsp_tdata[51])
      else $error("lookup hit with failure status or packet to send");

   a_send_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[51] |->
         (rsp_tdata[53:52] == ARP_OP_REQUEST[1:0] || rsp_tdata[53:52] == ARP_OP_REPLY[1:0])
         && rsp_tuser == STATUS_DONE)
      else $error("packet to send with bad opcode or failure status");

   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_DONE |-> rsp_tdata == '0)
      else $error("failed transfer carries payload");

endmodule

bind arp_cache_responder acr_checker u_checker (.*);
`default_nettype wire

@@ verif/arp_cache_responder_test.sv @@
// Self-checking testbench for arp_cache_responder: directed and random ARP traffic on the
// request stream, with an independent cache predictor and random back-pressure on responses.
// Depends on acr_pkg and arp_cache_responder only.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_responder_test;
   import acr_pkg::*;

   localparam int ENTRIES = DEFAULT_CACHE_ENTRIES;
   localparam int PORTS = DEFAULT_PORT_COUNT;
   localparam int MAX_GAP = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int POOL_MAX = 32;
   localparam int PRINT_LIMIT = 50;
   localparam logic [1:0] CSR_OWN_MAC = 2'd0;
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

   typedef struct packed {
      logic [2:0]         op;
      logic [15:0]        ptype;
      logic [15:0]        opcode;
      logic [MAC_W-1:0]   smac;
      logic [IP_W-1:0]    sip;
      logic [IP_W-1:0]    tip;
      logic [IP_W-1:0]    key;
      logic [IFACE_W-1:0] port;
   } arp_item_type;

   typedef struct packed {
      logic [1:0] status;
      rsp_type    data;
   } arp_outcome_type;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [MAC_W-1:0]   csr_data;
   logic               req_tvalid;
   logic               req_tready;
   logic [183:0]       req_tdata;
   logic [2:0]         req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [215:0]       rsp_tdata;
   logic [1:0]         rsp_tuser;

   // Predicted cache contents and register values.
   bit                 cache_valid [ENTRIES];
   logic [IP_W-1:0]    cache_ip [ENTRIES];
   logic [MAC_W-1:0]   cache_mac [ENTRIES];
   logic [IFACE_W-1:0] cache_port [ENTRIES];
   int unsigned        replace_ptr;
   logic [MAC_W-1:0]   cfg_own_mac;
   logic [IP_W-1:0]    cfg_own_ip;

   arp_outcome_type    arp_outcome_q [$];
   logic [IP_W-1:0]    ip_pool [POOL_MAX];
   int                 mismatches;
   bit                 sender_steady;

   arp_cache_responder u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
      end
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_mismatch(name, got, want);
      end
   endtask

   function automatic int find_entry(logic [IP_W-1:0] ip);
      for (int i = 0; i < ENTRIES; i++) begin
         if (cache_valid[i] && cache_ip[i] == ip) return i;
      end
      return -1;
   endfunction

   function automatic void store_entry(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                       logic [IFACE_W-1:0] port);
      int slot;
      slot = find_entry(ip);
      if (slot < 0) begin
         for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!cache_valid[i]) slot = i;
         end
      end
      if (slot < 0) begin
         slot = int'(replace_ptr);
         replace_ptr = (replace_ptr + 1) % ENTRIES;
      end
      cache_valid[slot] = 1'b1;
      cache_ip[slot] = ip;
      cache_mac[slot] = mac;
      cache_port[slot] = port;
   endfunction

   function automatic arp_outcome_type predict_arp_outcome(arp_item_type it);
      arp_outcome_type o;
      int slot;
      bit port_ok;
      o = '0;
      port_ok = int'(it.port) < PORTS;
      case (it.op)
         OP_RECEIVE: begin
            if (!port_ok) begin
               o.status = STATUS_NOT_FOUND;
            end else if (it.ptype != ETH_TYPE_IPV4) begin
               o.status = STATUS_BAD_PROTOCOL;
            end else begin
               store_entry(it.sip, it.smac, it.port);
               if (it.opcode == ARP_OP_REQUEST && cfg_own_ip != '0 &&
                   it.tip == cfg_own_ip) begin
                  o.data.send_valid = 1'b1;
                  o.data.send_opcode = ARP_OP_REPLY[1:0];
                  o.data.send_dest_mac = it.smac;
                  o.data.send_target_mac = it.smac;
                  o.data.send_target_ip = it.sip;
                  o.data.send_sender_ip = cfg_own_ip;
                  o.data.send_interface = it.port;
               end
            end
         end
         OP_LOOKUP: begin
            slot = find_entry(it.key);
            if (slot < 0) begin
               o.status = STATUS_NOT_FOUND;
            end else begin
               o.data.hit = 1'b1;
               o.data.found_mac = cache_mac[slot];
               o.data.found_interface = cache_port[slot];
            end
         end
         OP_ADD: begin
            if (!port_ok) o.status = STATUS_NOT_FOUND;
            else store_entry(it.key, it.smac, it.port);
         end
         OP_REMOVE: begin
            slot = find_entry(it.key);
            if (slot < 0) o.status = STATUS_NOT_FOUND;
            else cache_valid[slot] = 1'b0;
         end
         OP_SEND_REQUEST: begin
            if (!port_ok) begin
               o.status = STATUS_NOT_FOUND;
            end else begin
               o.data.send_valid = 1'b1;
               o.data.send_opcode = ARP_OP_REQUEST[1:0];
               o.data.send_dest_mac = BCAST_MAC;
               o.data.send_target_ip = it.key;
               o.data.send_sender_ip = cfg_own_ip;
               o.data.send_interface = it.port;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic arp_item_type make_item(logic [2:0] op, logic [15:0] ptype,
                                              logic [15:0] opcode, logic [MAC_W-1:0] smac,
                                              logic [IP_W-1:0] sip, logic [IP_W-1:0] tip,
                                              logic [IP_W-1:0] key,
                                              logic [IFACE_W-1:0] port);
      arp_item_type it;
      it.op = op;
      it.ptype = ptype;
      it.opcode = opcode;
      it.smac = smac;
      it.sip = sip;
      it.tip = tip;
      it.key = key;
      it.port = port;
      return it;
   endfunction

   function automatic logic [MAC_W-1:0] random_mac();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[MAC_W-1:0];
   endfunction

   function automatic logic [IP_W-1:0] pick_ip(int pool_size);
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return ip_pool[$urandom_range(0, pool_size - 1)];
      if (r < 92) return cfg_own_ip;
      return $urandom;
   endfunction

   function automatic arp_item_type random_item(int pool_size);
      arp_item_type it;
      int r;
      it.ptype = 16'($urandom);
      it.opcode = 16'($urandom);
      it.smac = random_mac();
      it.sip = pick_ip(pool_size);
      it.tip = pick_ip(pool_size);
      it.key = pick_ip(pool_size);
      it.port = IFACE_W'($urandom_range(0, 3));
      r = $urandom_range(0, 19);
      if (r == 0) it.smac = '0;
      else if (r == 1) it.smac = BCAST_MAC;
      r = $urandom_range(0, 99);
      if (r < 35) it.op = OP_RECEIVE;
      else if (r < 60) it.op = OP_LOOKUP;
      else if (r < 75) it.op = OP_ADD;
      else if (r < 87) it.op = OP_REMOVE;
      else if (r < 97) it.op = OP_SEND_REQUEST;
      else it.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      if (it.op == OP_RECEIVE) begin
         if ($urandom_range(0, 9) != 0) it.ptype = ETH_TYPE_IPV4;
         r = $urandom_range(0, 99);
         if (r < 60) it.opcode = ARP_OP_REQUEST;
         else if (r < 80) it.opcode = ARP_OP_REPLY;
         if ($urandom_range(0, 1) == 0) it.tip = cfg_own_ip;
      end
      return it;
   endfunction

   // A valid held high across back-to-back transfers is only reassigned once per step.
   task automatic send_item(arp_item_type it);
      int gap;
      req_tdata <= {6'b0, it.port, it.key, it.tip, it.sip, it.smac, it.opcode, it.ptype};
      req_tuser <= it.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      arp_outcome_q.push_back(predict_arp_outcome(it));
      gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_outstanding();
      req_tvalid <= 1'b0;
      while (arp_outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [MAC_W-1:0] value);
      wait_for_outstanding();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_OWN_MAC) cfg_own_mac = value;
      else if (index == CSR_OWN_IP) cfg_own_ip = value[IP_W-1:0];
   endtask

   task automatic check_response();
      arp_outcome_type want;
      rsp_type got;
      got = rsp_tdata;
      if (arp_outcome_q.size() == 0) begin
         report_mismatch("response with nothing outstanding", 64'(rsp_tuser), '0);
      end else begin
         want = arp_outcome_q.pop_front();
         check_field("status", 64'(rsp_tuser), 64'(want.status));
         check_field("hit", 64'(got.hit), 64'(want.data.hit));
         check_field("found_mac", 64'(got.found_mac), 64'(want.data.found_mac));
         check_field("found_interface", 64'(got.found_interface),
                     64'(want.data.found_interface));
         check_field("send_valid", 64'(got.send_valid), 64'(want.data.send_valid));
         check_field("send_opcode", 64'(got.send_opcode), 64'(want.data.send_opcode));
         check_field("send_dest_mac", 64'(got.send_dest_mac), 64'(want.data.send_dest_mac));
         check_field("send_target_mac", 64'(got.send_target_mac),
                     64'(want.data.send_target_mac));
         check_field("send_target_ip", 64'(got.send_target_ip),
                     64'(want.data.send_target_ip));
         check_field("send_sender_ip", 64'(got.send_sender_ip),
                     64'(want.data.send_sender_ip));
         check_field("send_interface", 64'(got.send_interface),
                     64'(want.data.send_interface));
      end
   endtask

   initial begin
      int stall;
      int steady_left;
      bit steady;
      steady_left = 0;
      steady = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (steady_left == 0) begin
            steady = $urandom_range(0, 3) == 0;
            steady_left = $urandom_range(10, 60);
         end
         steady_left--;
         stall = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_response();
      end
   end

   task automatic test_empty_cache();
      send_item(make_item(OP_LOOKUP, ETH_TYPE_IPV4, ARP_OP_REQUEST, '0, '0, '0,
                          '0, 2'd0));
      send_item(make_item(OP_REMOVE, '0, '0, '0, '0, '0, '1, 2'd1));
      send_item(make_item(OP_RECEIVE, '1, ARP_OP_REQUEST, '1, 32'h0A00_0001, '0,
                          '0, 2'd2));
      send_item(make_item(OP_RECEIVE, ETH_TYPE_IPV4, ARP_OP_REQUEST, '1,
                          32'h0000_0001, '0, '0, 2'd3));
      send_item(make_item(OP_SEND_REQUEST, '0, '0, '0, '0, '0, '1, 2'd0));
      for (logic [3:0] op = 4'(OP_UNUSED_FIRST); op <= 4'(OP_UNUSED_LAST); op++) begin
         send_item(make_item(op[2:0], '1, '1, '1, '1, '1, '1, 2'd3));
      end
   endtask

   task automatic test_table_ops();
      send_item(make_item(OP_ADD, '0, '0, '1, '0, '0, '1, 2'd3));
      send_item(make_item(OP_ADD, '1, '1, '0, '1, '1, '0, 2'd0));
      send_item(make_item(OP_LOOKUP, '0, '0, '0, '0, '0, '1, 2'd0));
      send_item(make_item(OP_LOOKUP, '0, '0, '0, '0, '0, '0, 2'd0));
      send_item(make_item(OP_ADD, '0, '0, 48'h1234_5678_9ABC, '0, '0, '0, 2'd2));
      send_item(make_item(OP_LOOKUP, '0, '0, '0, '0, '0, '0, 2'd1));
      send_item(make_item(OP_REMOVE, '0, '0, '0, '0, '0, '1, 2'd0));
      send_item(make_item(OP_LOOKUP, '0, '0, '0, '0, '0, '1, 2'd0));
      send_item(make_item(OP_LOOKUP, '0, '0, '0, '0, '0, 32'h0000_0001, 2'd0));
   endtask

   task automatic test_reply_generation();
      write_register(CSR_OWN_MAC, '1);
      write_register(CSR_OWN_IP, 48'hC0A8_0001);
      send_item(make_item(OP_RECEIVE, ETH_TYPE_IPV4, ARP_OP_REQUEST,
                          48'h0200_0000_0042, 32'hC0A8_0002, 32'hC0A8_0001, '0, 2'd1));
      send_item(make_item(OP_RECEIVE, ETH_TYPE_IPV4, ARP_OP_REPLY,
                          48'h0200_0000_0043, 32'hC0A8_0003, 32'hC0A8_0001, '0, 2'd2));
      send_item(make_item(OP_RECEIVE, ETH_TYPE_IPV4, '1, 48'h0200_0000_0044,
                          32'hC0A8_0004, 32'hC0A8_0001, '0, 2'd3));
      send_item(make_item(OP_RECEIVE, ETH_TYPE_IPV4, ARP_OP_REQUEST,
                          48'h0200_0000_0045, 32'hC0A8_0005, 32'hC0A8_0009, '0, 2'd0));
      send_item(make_item(OP_SEND_REQUEST, '0, '0, '0, '0, '0, 32'hC0A8_0002, 2'd3));
      write_register(CSR_OWN_IP, 48'hFFFF_FFFF);
      send_item(make_item(OP_RECEIVE, ETH_TYPE_IPV4, ARP_OP_REQUEST, '1, '1, '1,
                          '0, 2'd3));
   endtask

   task automatic test_random_traffic(int count, int pool_size);
      int steady_left;
      steady_left = 0;
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int i = 2; i < POOL_MAX; i++) ip_pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         if (steady_left == 0) begin
            sender_steady = $urandom_range(0, 3) == 0;
            steady_left = $urandom_range(10, 60);
         end
         steady_left--;
         send_item(random_item(pool_size));
      end
      sender_steady = 1'b0;
   endtask

   initial begin
      mismatches = 0;
      sender_steady = 1'b0;
      replace_ptr = 0;
      cfg_own_mac = '0;
      cfg_own_ip = '0;
      for (int i = 0; i < ENTRIES; i++) cache_valid[i] = 1'b0;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_cache();
      test_table_ops();
      test_reply_generation();

      write_register(CSR_OWN_IP, 48'($urandom));
      test_random_traffic(390, 20);
      write_register(CSR_OWN_MAC, '0);
      write_register(CSR_OWN_IP, 48'hFFFF_FFFF);
      test_random_traffic(390, 24);
      write_register(CSR_OWN_MAC, random_mac());
      write_register(CSR_OWN_IP, '0);
      test_random_traffic(390, 12);
      write_register(CSR_OWN_IP, 48'h1);
      test_random_traffic(390, 30);
      write_register(CSR_OWN_MAC, random_mac());
      write_register(CSR_OWN_IP, 48'($urandom));
      test_random_traffic(390, 18);

      wait_for_outstanding();
      repeat (20) @(posedge clock);
      if (arp_outcome_q.size() != 0) begin
         report_mismatch("responses still outstanding", 64'(arp_outcome_q.size()), '0);
      end
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
